// ===== design/eas_pkg.sv =====
// Package for the encoder angle and speed estimator: widths, register
// indexes, reset values and the sequencer state type.
// No dependencies; used by encoder_angle_speed_estimator.
`default_nettype none

package eas_pkg;

  localparam int CNT_W      = 16;  // position count width
  localparam int OFS_W      = 17;  // signed calibration offset
  localparam int PP_W       = 7;   // pole pairs
  localparam int SCALE_W    = 32;  // turn fraction per count, Q16.16
  localparam int PERIOD_W   = 8;   // ticks between speed samples
  localparam int IN_W       = 24;  // input tdata, padded to bytes
  localparam int OUT_W      = 72;  // output tdata, padded to bytes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Bit-serial step counts
  localparam int DIV_STEPS = CNT_W + 1;   // remainder over a 17-bit numerator
  localparam int MUL_STEPS = CNT_W;       // shift-add over a 16-bit multiplicand
  localparam int MM_STEPS  = 2 * PP_W;    // modular Horner, two phases a bit
  localparam int STEP_W    = 5;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
  localparam logic [STEP_W-1:0] MUL_END  = STEP_W'(MUL_STEPS);
  localparam logic [STEP_W-1:0] MM_END   = STEP_W'(MM_STEPS);

  // Register reset values
  localparam logic [CNT_W-1:0]    REV_COUNTS_RST   = 16'd4096;
  localparam logic [OFS_W-1:0]    ANGLE_OFFSET_RST = 17'd0;
  localparam logic [PP_W-1:0]     POLE_PAIRS_RST   = 7'd4;
  localparam logic [SCALE_W-1:0]  COUNT_SCALE_RST  = 32'd1048576;
  localparam logic [PERIOD_W-1:0] SPEED_PERIOD_RST = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REV_COUNTS   = 3'd0,
    REG_ANGLE_OFFSET = 3'd1,
    REG_POLE_PAIRS   = 3'd2,
    REG_COUNT_SCALE  = 3'd3,
    REG_SPEED_PERIOD = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,    // wait for a tick request
    S_MODPOS,  // pos_count mod the modulus
    S_SUM,     // add the calibration offset
    S_MODSUM,  // wrap the sum
    S_MECH,    // fix the sign, start angle multiply and electrical reduction
    S_MMUL,    // mechanical turn multiply with modular pole-pair product
    S_ELEC,    // start electrical turn multiply and old position reduction
    S_MULE,    // electrical turn multiply with old position remainder
    S_SPDA,    // compare positions, classify wrap
    S_SPDB,    // magnitude of the change, update held values
    S_MULS,    // speed turn multiply
    S_DONE     // hand the result to the output register
  } st_t;

endpackage

`default_nettype wire

// ===== design/encoder_angle_speed_estimator.sv =====
// Quadrature encoder angle and speed estimator, top level.
// Depends on eas_pkg (widths, register indexes, state type).
`default_nettype none

// Each tick request carries the encoder position count, the latched index
// flag and the direction flag, and yields one result: the mechanical angle
// ((count + angle_offset) wrapped into 0..rev_counts-1) and the electrical
// angle (mechanical count times pole_pairs, mod rev_counts), both as 16-bit
// fractions of a turn, plus the speed sample taken every speed_period ticks
// once an index has been seen. The work is done by a bit-serial remainder
// unit (17 steps, run three times) and a shift-add multiplier (16 steps, run
// three times); the remainder unit and the modular pole-pair product share
// a single compare-and-subtract against rev_counts. The output register
// lets a new tick be taken while the previous result still waits; a finished
// result holds in the last sequencer state until the output side is free.
// Configuration writes are taken in any cycle but must only be issued while
// the block is idle. There is no clearing pass after reset.

module encoder_angle_speed_estimator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Tick requests
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [15:0] pos_count, [16] index_flag, [17] dir_flag, [23:18] zero
  input  wire logic [eas_pkg::IN_W-1:0]      in_tdata,
  // Results
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] index_seen, [1] reverse, [17:2] mech_angle, [33:18] elec_angle,
  // [34] speed_valid, [50:35] speed_counts, [66:51] speed_turns, [71:67] zero
  output logic [eas_pkg::OUT_W-1:0]          out_tdata,
  // Configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [eas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [eas_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = eas_pkg::CNT_W;
  localparam int DW = eas_pkg::DIV_STEPS;
  localparam int SW = eas_pkg::STEP_W;

  // Configuration registers
  logic [CW-1:0]                rev_counts_r;
  logic [eas_pkg::OFS_W-1:0]    angle_offset_r;
  logic [eas_pkg::PP_W-1:0]     pole_pairs_r;
  logic [eas_pkg::SCALE_W-1:0]  count_scale_r;
  logic [eas_pkg::PERIOD_W-1:0] speed_period_r;

  // Control and persistent state
  eas_pkg::st_t                 state_r, state_nxt;
  logic [SW-1:0]                cnt_r, cnt_nxt;
  logic                         index_found_r, index_found_nxt;
  logic [eas_pkg::PERIOD_W-1:0] tick_count_r, tick_count_nxt;
  logic [CW-1:0]                last_pos_r, last_pos_nxt;
  logic [CW-1:0]                held_delta_r, held_delta_nxt;
  logic                         sample_r, sample_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;

  // Datapath registers
  logic                         idx_r, idx_nxt;
  logic                         dir_r, dir_nxt;
  logic [DW-1:0]                div_num_r, div_num_nxt;
  logic [CW-1:0]                div_rem_r, div_rem_nxt;
  logic [CW-1:0]                pos_r, pos_nxt;
  logic                         sum_neg_r, sum_neg_nxt;
  logic [CW-1:0]                mech_r, mech_nxt;
  logic [CW-1:0]                mm_acc_r, mm_acc_nxt;
  logic [eas_pkg::PP_W-1:0]     mm_pp_r, mm_pp_nxt;
  logic [eas_pkg::SCALE_W-1:0]  mul_acc_r, mul_acc_nxt;
  logic [CW-1:0]                mul_x_r, mul_x_nxt;
  logic [CW-1:0]                mech_turn_r, mech_turn_nxt;
  logic [CW-1:0]                elec_turn_r, elec_turn_nxt;
  logic                         wrap_r, wrap_nxt;
  logic                         fwd_r, fwd_nxt;
  logic [CW-1:0]                absdiff_r, absdiff_nxt;
  logic [eas_pkg::OUT_W-1:0]    out_tdata_r, out_tdata_nxt;

  // Shared arithmetic
  logic [CW-1:0]                modulus;
  logic [CW-1:0]                quarter;
  logic [CW+1:0]                three_sum;
  logic [CW-1:0]                three_q;
  logic [CW:0]                  red_in;
  logic [CW:0]                  red_diff;
  logic [CW-1:0]                red_out;
  logic [eas_pkg::SCALE_W:0]    mul_sum;
  logic [eas_pkg::PERIOD_W-1:0] tick_inc;
  logic                         found_acc;
  logic                         sample_now;
  logic signed [CW+1:0]         sum_s;
  logic [CW+1:0]                sum_abs;
  logic [CW-1:0]                mech_val;
  logic                         wrap_a;
  logic                         wrap_b;
  logic                         pos_gt;
  logic [CW-1:0]                delta_val;
  logic [CW-1:0]                speed_turns;
  logic                         out_load;

  // A modulus of zero behaves as one
  assign modulus   = (rev_counts_r == '0) ? CW'(1) : rev_counts_r;
  assign quarter   = {2'b00, modulus[CW-1:2]};
  assign three_sum = {2'b00, modulus} + {1'b0, modulus, 1'b0};
  assign three_q   = three_sum[CW+1:2];

  // Single conditional subtract of the modulus; every input is below twice it
  assign red_diff = red_in - {1'b0, modulus};
  assign red_out  = (red_in >= {1'b0, modulus}) ? red_diff[CW-1:0] : red_in[CW-1:0];

  // Right-shifting shift-add: after all steps the accumulator holds product >> 16
  assign mul_sum = {1'b0, mul_acc_r} +
                   (mul_x_r[0] ? {1'b0, count_scale_r} : '0);

  // Tick bookkeeping: apply the index first, then count with saturation
  assign found_acc  = index_found_r | in_tdata[CW];
  assign tick_inc   = (tick_count_r == '1) ? tick_count_r : tick_count_r + 1'b1;
  assign sample_now = (tick_inc >= speed_period_r) && found_acc;

  assign speed_turns = (mul_acc_r[eas_pkg::SCALE_W-1:CW] != '0) ? '1 : mul_acc_r[CW-1:0];

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Compare-and-subtract operand: the Horner steps own it during S_MMUL,
  // the remainder unit the rest of the time
  always_comb begin
    red_in = {div_rem_r, div_num_r[DW-1]};
    if (state_r == eas_pkg::S_MMUL) begin
      if (!cnt_r[0]) begin
        red_in = {mm_acc_r, 1'b0};
      end else begin
        red_in = {1'b0, mm_acc_r} + {1'b0, mech_r};
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    index_found_nxt = index_found_r;
    tick_count_nxt  = tick_count_r;
    last_pos_nxt    = last_pos_r;
    held_delta_nxt  = held_delta_r;
    sample_nxt      = sample_r;
    idx_nxt         = idx_r;
    dir_nxt         = dir_r;
    div_num_nxt     = div_num_r;
    div_rem_nxt     = div_rem_r;
    pos_nxt         = pos_r;
    sum_neg_nxt     = sum_neg_r;
    mech_nxt        = mech_r;
    mm_acc_nxt      = mm_acc_r;
    mm_pp_nxt       = mm_pp_r;
    mul_acc_nxt     = mul_acc_r;
    mul_x_nxt       = mul_x_r;
    mech_turn_nxt   = mech_turn_r;
    elec_turn_nxt   = elec_turn_r;
    wrap_nxt        = wrap_r;
    fwd_nxt         = fwd_r;
    absdiff_nxt     = absdiff_r;
    in_tready       = 1'b0;
    out_load        = 1'b0;
    sum_s           = '0;
    sum_abs         = '0;
    mech_val        = '0;
    wrap_a          = 1'b0;
    wrap_b          = 1'b0;
    pos_gt          = 1'b0;
    delta_val       = '0;

    case (state_r)
      eas_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          idx_nxt         = in_tdata[CW];
          dir_nxt         = in_tdata[CW+1];
          index_found_nxt = found_acc;
          tick_count_nxt  = sample_now ? '0 : tick_inc;
          sample_nxt      = sample_now;
          div_num_nxt     = {1'b0, in_tdata[CW-1:0]};
          div_rem_nxt     = '0;
          cnt_nxt         = '0;
          state_nxt       = eas_pkg::S_MODPOS;
        end
      end

      eas_pkg::S_MODPOS: begin
        div_rem_nxt = red_out;
        div_num_nxt = {div_num_r[DW-2:0], 1'b0};
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == eas_pkg::DIV_LAST) begin
          state_nxt = eas_pkg::S_SUM;
        end
      end

      eas_pkg::S_SUM: begin
        pos_nxt     = div_rem_r;
        sum_s       = $signed({2'b00, div_rem_r}) +
                      $signed({angle_offset_r[eas_pkg::OFS_W-1], angle_offset_r});
        sum_neg_nxt = sum_s[CW+1];
        sum_abs     = sum_s[CW+1] ? 18'(-sum_s) : 18'(sum_s);
        div_num_nxt = sum_abs[DW-1:0];
        div_rem_nxt = '0;
        cnt_nxt     = '0;
        state_nxt   = eas_pkg::S_MODSUM;
      end

      eas_pkg::S_MODSUM: begin
        div_rem_nxt = red_out;
        div_num_nxt = {div_num_r[DW-2:0], 1'b0};
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == eas_pkg::DIV_LAST) begin
          state_nxt = eas_pkg::S_MECH;
        end
      end

      eas_pkg::S_MECH: begin
        // A negative sum with a nonzero remainder folds up by the modulus
        mech_val    = (sum_neg_r && (div_rem_r != '0)) ? modulus - div_rem_r : div_rem_r;
        mech_nxt    = mech_val;
        mul_x_nxt   = mech_val;
        mul_acc_nxt = '0;
        mm_acc_nxt  = '0;
        mm_pp_nxt   = pole_pairs_r;
        cnt_nxt     = '0;
        state_nxt   = eas_pkg::S_MMUL;
      end

      eas_pkg::S_MMUL: begin
        mul_acc_nxt = mul_sum[eas_pkg::SCALE_W:1];
        mul_x_nxt   = {1'b0, mul_x_r[CW-1:1]};
        if (cnt_r < eas_pkg::MM_END) begin
          if (!cnt_r[0]) begin
            mm_acc_nxt = red_out;
          end else begin
            if (mm_pp_r[eas_pkg::PP_W-1]) begin
              mm_acc_nxt = red_out;
            end
            mm_pp_nxt = {mm_pp_r[eas_pkg::PP_W-2:0], 1'b0};
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == eas_pkg::MUL_LAST) begin
          state_nxt = eas_pkg::S_ELEC;
        end
      end

      eas_pkg::S_ELEC: begin
        mech_turn_nxt = mul_acc_r[CW-1:0];
        mul_x_nxt     = mm_acc_r;
        mul_acc_nxt   = '0;
        div_num_nxt   = {1'b0, last_pos_r};
        div_rem_nxt   = '0;
        cnt_nxt       = '0;
        state_nxt     = eas_pkg::S_MULE;
      end

      eas_pkg::S_MULE: begin
        div_rem_nxt = red_out;
        div_num_nxt = {div_num_r[DW-2:0], 1'b0};
        if (cnt_r < eas_pkg::MUL_END) begin
          mul_acc_nxt = mul_sum[eas_pkg::SCALE_W:1];
          mul_x_nxt   = {1'b0, mul_x_r[CW-1:1]};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == eas_pkg::DIV_LAST) begin
          state_nxt = eas_pkg::S_SPDA;
        end
      end

      eas_pkg::S_SPDA: begin
        // div_rem_r now holds the previous sample position reduced by the modulus
        elec_turn_nxt = mul_acc_r[CW-1:0];
        wrap_a        = (pos_r < quarter) && (div_rem_r > three_q);
        wrap_b        = (div_rem_r < quarter) && (pos_r > three_q);
        pos_gt        = pos_r > div_rem_r;
        wrap_nxt      = wrap_a | wrap_b;
        fwd_nxt       = wrap_a | (!wrap_b & pos_gt);
        absdiff_nxt   = pos_gt ? pos_r - div_rem_r : div_rem_r - pos_r;
        state_nxt     = eas_pkg::S_SPDB;
      end

      eas_pkg::S_SPDB: begin
        // Across a wrap the distance runs the other way round the turn
        delta_val = wrap_r ? modulus - absdiff_r : absdiff_r;
        if (sample_r) begin
          held_delta_nxt = delta_val;
          last_pos_nxt   = pos_r;
        end
        mul_x_nxt   = sample_r ? delta_val : held_delta_r;
        mul_acc_nxt = '0;
        cnt_nxt     = '0;
        state_nxt   = eas_pkg::S_MULS;
      end

      eas_pkg::S_MULS: begin
        mul_acc_nxt = mul_sum[eas_pkg::SCALE_W:1];
        mul_x_nxt   = {1'b0, mul_x_r[CW-1:1]};
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == eas_pkg::MUL_LAST) begin
          state_nxt = eas_pkg::S_DONE;
        end
      end

      eas_pkg::S_DONE: begin
        // Hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = eas_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = eas_pkg::S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tdata_nxt = {5'b00000, speed_turns, held_delta_r, sample_r,
                       elec_turn_r, mech_turn_r,
                       sample_r ? !fwd_r : !dir_r, idx_r};
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_counts_r   <= eas_pkg::REV_COUNTS_RST;
      angle_offset_r <= eas_pkg::ANGLE_OFFSET_RST;
      pole_pairs_r   <= eas_pkg::POLE_PAIRS_RST;
      count_scale_r  <= eas_pkg::COUNT_SCALE_RST;
      speed_period_r <= eas_pkg::SPEED_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        eas_pkg::REG_REV_COUNTS:   rev_counts_r   <= cfg_data[CW-1:0];
        eas_pkg::REG_ANGLE_OFFSET: angle_offset_r <= cfg_data[eas_pkg::OFS_W-1:0];
        eas_pkg::REG_POLE_PAIRS:   pole_pairs_r   <= cfg_data[eas_pkg::PP_W-1:0];
        eas_pkg::REG_COUNT_SCALE:  count_scale_r  <= cfg_data[eas_pkg::SCALE_W-1:0];
        eas_pkg::REG_SPEED_PERIOD: speed_period_r <= cfg_data[eas_pkg::PERIOD_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= eas_pkg::S_IDLE;
      cnt_r         <= '0;
      index_found_r <= 1'b0;
      tick_count_r  <= '0;
      last_pos_r    <= '0;
      held_delta_r  <= '0;
      sample_r      <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      index_found_r <= index_found_nxt;
      tick_count_r  <= tick_count_nxt;
      last_pos_r    <= last_pos_nxt;
      held_delta_r  <= held_delta_nxt;
      sample_r      <= sample_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    dir_r       <= dir_nxt;
    div_num_r   <= div_num_nxt;
    div_rem_r   <= div_rem_nxt;
    pos_r       <= pos_nxt;
    sum_neg_r   <= sum_neg_nxt;
    mech_r      <= mech_nxt;
    mm_acc_r    <= mm_acc_nxt;
    mm_pp_r     <= mm_pp_nxt;
    mul_acc_r   <= mul_acc_nxt;
    mul_x_r     <= mul_x_nxt;
    mech_turn_r <= mech_turn_nxt;
    elec_turn_r <= elec_turn_nxt;
    wrap_r      <= wrap_nxt;
    fwd_r       <= fwd_nxt;
    absdiff_r   <= absdiff_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // Assertions
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r == eas_pkg::S_MODPOS) && !in_tready)
    else $error("accepted tick did not start the remainder pass");

  a_sample_needs_index: assert property (@(posedge clk) disable iff (!rst_n)
    sample_r |-> index_found_r)
    else $error("speed sample flagged before any index");

  a_sample_clears_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && sample_now |=> tick_count_r == '0)
    else $error("tick counter not cleared by a speed sample");

  a_mult_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == eas_pkg::S_MULE) && (cnt_r == eas_pkg::DIV_LAST) |-> mul_x_r == '0)
    else $error("electrical multiply ran short of its steps");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == eas_pkg::S_DONE) && (!out_tvalid_r || out_tready)
      |=> out_tvalid_r && (state_r == eas_pkg::S_IDLE))
    else $error("finished result not moved to the output register");

endmodule

`default_nettype wire
